/* hw/rtl/pixel_histogram_defines.svh */
// Assertion macros for the pixel histogram checker.
`ifndef PIXEL_HISTOGRAM_DEFINES_SVH
`define PIXEL_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PHIST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pixel_histogram check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PHIST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pixel_histogram check failed");

`endif

/* hw/rtl/phist_pkg.sv */
// Shared constants, types and functions of the pixel histogram.
`timescale 1ns / 1ps
`default_nettype none

package phist_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 32;
    localparam int ADDR_W     = $clog2(BIN_COUNT);
    localparam int OUT_BITS   = 32;
    localparam logic [7:0] MAX_VALUE_RESET = 8'd255;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic add;
        logic read;
        logic clear;
    } t_ctrl_cmd;

    function automatic logic [OUT_BITS-1:0] sat_out(input t_count c);
        logic [63:0] wide;
        logic [63:0] lim;
        wide = 64'(c);
        lim  = {{(64-OUT_BITS){1'b0}}, {OUT_BITS{1'b1}}};
        return (wide > lim) ? {OUT_BITS{1'b1}} : OUT_BITS'(wide);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/phist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module phist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/phist_ctrl.sv */
// Controller state machine of the pixel histogram.
`timescale 1ns / 1ps
`default_nettype none

module phist_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  phist_pkg::t_action    i_action,
    output phist_pkg::t_ctrl_cmd  o_cmd,
    output logic                  o_busy
);

    phist_pkg::t_state r_state;
    phist_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phist_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b0;
        case (r_state)
            phist_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = phist_pkg::ST_EXEC;
                end
            end
            phist_pkg::ST_EXEC: begin
                o_busy  = 1'b1;
                n_state = phist_pkg::ST_IDLE;
                case (i_action)
                    phist_pkg::ACT_ADD:   o_cmd.add   = 1'b1;
                    phist_pkg::ACT_READ:  o_cmd.read  = 1'b1;
                    phist_pkg::ACT_CLEAR: o_cmd.clear = 1'b1;
                    default: ;
                endcase
            end
            default: begin
                n_state = phist_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/phist_dp.sv */
// Datapath of the pixel histogram: bin store, valid bits, counter update, result register.
`timescale 1ns / 1ps
`default_nettype none

module phist_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  phist_pkg::t_ctrl_cmd  i_cmd,
    input  wire [1:0]             i_action,
    input  wire [7:0]             i_pixel_value,
    input  wire [7:0]             i_bin_select,
    input  wire                   i_cfg_wr_en,
    input  wire [7:0]             i_cfg_wr_data,
    output phist_pkg::t_action    o_action,
    output logic                  o_strobe,
    output logic [7:0]            o_bin_number,
    output logic [31:0]           o_bin_count,
    output logic                  o_bin_valid
);

    logic [7:0]                     r_max_value;
    phist_pkg::t_action             r_action;
    logic [7:0]                     r_sel;
    phist_pkg::t_addr               r_addr;
    logic [phist_pkg::BIN_COUNT-1:0] r_valid;
    logic                           r_strobe;
    logic [7:0]                     r_out_bin;
    logic [phist_pkg::OUT_BITS-1:0] r_out_cnt;
    logic                           r_out_vld;

    logic [7:0]         n_sel;
    phist_pkg::t_count  rd_data;
    phist_pkg::t_count  cur;
    logic               live;
    logic               ram_we;

    assign n_sel = (phist_pkg::t_action'(i_action) == phist_pkg::ACT_READ) ?
                   i_bin_select : i_pixel_value;

    phist_ram #(
        .WIDTH(phist_pkg::COUNT_BITS),
        .DEPTH(phist_pkg::BIN_COUNT)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(cur + phist_pkg::COUNT_BITS'(1)),
        .i_re   (i_cmd.load),
        .i_raddr(phist_pkg::ADDR_W'(n_sel)),
        .o_rdata(rd_data)
    );

    assign live   = (r_sel <= r_max_value) && (32'(r_sel) < phist_pkg::BIN_COUNT);
    assign cur    = r_valid[r_addr] ? rd_data : '0;
    assign ram_we = i_cmd.add && live && (cur != {phist_pkg::COUNT_BITS{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= phist_pkg::MAX_VALUE_RESET;
            r_valid     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_value <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            r_strobe <= i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= phist_pkg::t_action'(i_action);
            r_sel    <= n_sel;
            r_addr   <= phist_pkg::ADDR_W'(n_sel);
        end
        if (i_cmd.read) begin
            r_out_bin <= r_sel;
            r_out_cnt <= live ? phist_pkg::sat_out(cur) : '0;
            r_out_vld <= live;
        end
    end

    assign o_action     = r_action;
    assign o_strobe     = r_strobe;
    assign o_bin_number = r_out_bin;
    assign o_bin_count  = r_out_cnt;
    assign o_bin_valid  = r_out_vld;

endmodule

`default_nettype wire

/* hw/rtl/pixel_histogram.sv */
// Top level of the pixel histogram: controller and datapath.
//
// Input channel: an item (i_action, i_pixel_value, i_bin_select) is taken at a
// rising edge with i_start high and o_busy low. Action add raises the bin of
// i_pixel_value by one, saturating; pixels above the max value are dropped.
// Action read reports one bin; action clear zeroes every bin at once.
// Every item has an accept step, which issues the bin store read, and an
// execute step, in which o_busy is high and the read-modify-write or the
// clear completes. The store's registered read port sets this. No new item
// is taken while the previous one executes.
// Result channel: a read item's result shows on o_bin_number, o_bin_count and
// o_bin_valid with o_strobe high for one cycle, registered from the execute step.
// The receiver cannot stall; each transaction is taken as it appears.
// Configuration: i_cfg_wr_en writes the max value from i_cfg_wr_data; write
// only while idle. Changing it keeps the counts.
// Reset: i_rst_n low clears all bins through per-bin valid bits at once and
// sets the max value to 255; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pixel_histogram (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [1:0]  i_action,
    input  wire  [7:0]  i_pixel_value,
    input  wire  [7:0]  i_bin_select,
    input  wire         i_cfg_wr_en,
    input  wire  [7:0]  i_cfg_wr_data,
    output logic        o_strobe,
    output logic [7:0]  o_bin_number,
    output logic [31:0] o_bin_count,
    output logic        o_bin_valid
);

    phist_pkg::t_ctrl_cmd cmd;
    phist_pkg::t_action   action;

    phist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_action(action),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    phist_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_pixel_value(i_pixel_value),
        .i_bin_select (i_bin_select),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_action     (action),
        .o_strobe     (o_strobe),
        .o_bin_number (o_bin_number),
        .o_bin_count  (o_bin_count),
        .o_bin_valid  (o_bin_valid)
    );

endmodule

`default_nettype wire

/* hw/rtl/phist_checker.sv */
// Port-level assertions of the pixel histogram and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_histogram_defines.svh"

module phist_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_start,
    input wire        o_busy,
    input wire [1:0]  i_action,
    input wire        o_strobe,
    input wire [31:0] o_bin_count,
    input wire        o_bin_valid
);

    logic accept;
    logic accept_read;

    assign accept      = i_start && !o_busy;
    assign accept_read = accept && (i_action == phist_pkg::ACT_READ);

    `PHIST_ASSERT_NEXT(a_accept_busy, accept, o_busy)
    `PHIST_ASSERT_NEXT(a_busy_one_cycle, o_busy, !o_busy)
    `PHIST_ASSERT_SAME(a_read_result, accept_read, ##2 o_strobe)
    `PHIST_ASSERT_SAME(a_invalid_zero, o_strobe && !o_bin_valid, o_bin_count == 32'd0)

endmodule

bind pixel_histogram phist_checker u_checker (.*);

`default_nettype wire
